[hw/rtl/sbsvm_pkg.sv]
`timescale 1ns / 1ps
package sbsvm_pkg;
    localparam int ADDR_W = 15;
    localparam int WORD_W = 16;

    typedef enum logic [2:0] {
        FAULT_NONE    = 3'd0,
        FAULT_OPCODE  = 3'd1,
        FAULT_DEST    = 3'd2,
        FAULT_EMPTY   = 3'd3,
        FAULT_MODZERO = 3'd4,
        FAULT_FULL    = 3'd5
    } fault_t;

    localparam logic [4:0] OP_HALT = 5'd0;
    localparam logic [4:0] OP_SET  = 5'd1;
    localparam logic [4:0] OP_PUSH = 5'd2;
    localparam logic [4:0] OP_POP  = 5'd3;
    localparam logic [4:0] OP_EQ   = 5'd4;
    localparam logic [4:0] OP_GT   = 5'd5;
    localparam logic [4:0] OP_JMP  = 5'd6;
    localparam logic [4:0] OP_JT   = 5'd7;
    localparam logic [4:0] OP_JF   = 5'd8;
    localparam logic [4:0] OP_ADD  = 5'd9;
    localparam logic [4:0] OP_MULT = 5'd10;
    localparam logic [4:0] OP_MOD  = 5'd11;
    localparam logic [4:0] OP_AND  = 5'd12;
    localparam logic [4:0] OP_OR   = 5'd13;
    localparam logic [4:0] OP_NOT  = 5'd14;
    localparam logic [4:0] OP_RMEM = 5'd15;
    localparam logic [4:0] OP_WMEM = 5'd16;
    localparam logic [4:0] OP_CALL = 5'd17;
    localparam logic [4:0] OP_RET  = 5'd18;
    localparam logic [4:0] OP_OUT  = 5'd19;
    localparam logic [4:0] OP_IN   = 5'd20;
    localparam logic [4:0] OP_NOOP = 5'd21;

    // register operand test
    function automatic logic is_reg(input logic [WORD_W-1:0] w);
        is_reg = (w[15:3] == 13'h1000);
    endfunction

    // divider handshake
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] remainder;
    } div_rsp_t;
endpackage

[hw/rtl/sbsvm_mod_unit.sv]
`timescale 1ns / 1ps
module sbsvm_mod_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sbsvm_pkg::div_req_t  req,
    output sbsvm_pkg::div_rsp_t  rsp
);
    import sbsvm_pkg::*;

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] dsr_reg, dsr_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   shifted;

    // restoring division, one bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[WORD_W-1]};
        trial     = shifted - {1'b0, dsr_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
            cnt_next  = 5'(WORD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            if (!trial[WORD_W])
                rem_next = trial[WORD_W-1:0];
            else
                rem_next = shifted[WORD_W-1:0];
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;
endmodule

[hw/rtl/sixteen_bit_stack_vm_core_unit.sv]
`timescale 1ns / 1ps
// channel  | direction | tdata fields (low bit up)                      | tuser
// s_axis   | in        | load_address[14:0] load_word[30:15] in_char[38:31] | op
// m_axis   | out       | pc[14:0] out_char[22:15] fault[25:23]          | out_valid in_taken halted
//
// a load request, or a step on a stopped machine, goes from accept to result.
// a step has the accept state, four instruction-word fetches from the single main
// memory port, one execute state and the result state. rmem adds a state for its
// data read and mod waits in a further state for the bit-serial remainder unit.
// after reset a clearing pass writes zero over all MEM_WORDS words, one per
// cycle, before the first request is taken.
// the result register holds while m_axis_tready is low; no new request enters.
module sixteen_bit_stack_vm_core_unit #(
    parameter int STACK_DEPTH = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // load_address, load_word, in_char
    input  logic        s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // pc, out_char, fault
    output logic [2:0]  m_axis_tuser   // out_valid, in_taken, halted
);
    import sbsvm_pkg::*;

    localparam int MEM_WORDS = 32768;
    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam int LV_W = SP_W + 1;

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_F0    = 10'b0000000100,
        S_F1    = 10'b0000001000,
        S_F2    = 10'b0000010000,
        S_F3    = 10'b0000100000,
        S_EXEC  = 10'b0001000000,
        S_DATA  = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // memories
    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [WORD_W-1:0] stk [STACK_DEPTH];
    logic [WORD_W-1:0] mem_rd, stk_rd;
    logic [ADDR_W-1:0] mem_addr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_we;
    logic [SP_W-1:0]   stk_addr;
    logic [WORD_W-1:0] stk_wdata;
    logic              stk_we;

    logic [WORD_W-1:0] regs_reg [8];
    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic [LV_W-1:0]   lvl_reg, lvl_next;
    logic              stop_reg, stop_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [4:0]        opc_reg, opc_next;
    logic [WORD_W-1:0] wa_reg, wa_next, wb_reg, wb_next, wc_reg, wc_next;
    logic              opbad_reg, opbad_next;
    logic [7:0]        inc_reg, inc_next;

    logic              rwe;
    logic [2:0]        rsel;
    logic [WORD_W-1:0] rval;

    logic [ADDR_W-1:0] o_pc_reg, o_pc_next;
    logic [7:0]        o_ch_reg, o_ch_next;
    logic [2:0]        o_flt_reg, o_flt_next;
    logic              o_ov_reg, o_ov_next, o_it_reg, o_it_next;

    div_req_t dreq;
    div_rsp_t drsp;

    sbsvm_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // main memory, one port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        mem_rd <= mem[mem_addr];
    end

    // call stack, one port
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk[stk_addr] <= stk_wdata;
        stk_rd <= stk[stk_addr];
    end

    // operand values from the captured instruction words
    logic [WORD_W-1:0] va, vb, vc;
    always_comb
    begin
        va = is_reg(wa_reg) ? regs_reg[wa_reg[2:0]] : wa_reg;
        vb = is_reg(wb_reg) ? regs_reg[wb_reg[2:0]] : wb_reg;
        vc = is_reg(wc_reg) ? regs_reg[wc_reg[2:0]] : wc_reg;
    end

    // control and execution
    always_comb
    begin
        logic [31:0] prod;
        logic        dst_ok;
        logic        empty;
        logic        full;
        state_next = state_reg;
        pc_next    = pc_reg;
        lvl_next   = lvl_reg;
        stop_next  = stop_reg;
        clr_next   = clr_reg;
        opc_next   = opc_reg;
        opbad_next = opbad_reg;
        wa_next    = wa_reg;
        wb_next    = wb_reg;
        wc_next    = wc_reg;
        inc_next   = inc_reg;
        mem_addr   = pc_reg;
        mem_wdata  = '0;
        mem_we     = 1'b0;
        stk_addr   = lvl_reg[SP_W-1:0];
        stk_wdata  = '0;
        stk_we     = 1'b0;
        rwe        = 1'b0;
        rsel       = wa_reg[2:0];
        rval       = '0;
        dreq       = '0;
        o_pc_next  = o_pc_reg;
        o_ch_next  = o_ch_reg;
        o_flt_next = o_flt_reg;
        o_ov_next  = o_ov_reg;
        o_it_next  = o_it_reg;
        s_axis_tready = 1'b0;
        prod   = 32'(vb) * 32'(vc);
        dst_ok = is_reg(wa_reg);
        empty  = (lvl_reg == '0);
        full   = (lvl_reg == LV_W'(STACK_DEPTH));

        case (state_reg)
            S_CLEAR:
            begin
                mem_addr  = clr_reg;
                mem_we    = 1'b1;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(MEM_WORDS - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    inc_next   = s_axis_tdata[38:31];
                    o_pc_next  = pc_reg;
                    o_ch_next  = '0;
                    o_flt_next = FAULT_NONE;
                    o_ov_next  = 1'b0;
                    o_it_next  = 1'b0;
                    if (!s_axis_tuser)
                    begin
                        mem_addr   = s_axis_tdata[14:0];
                        mem_wdata  = s_axis_tdata[30:15];
                        mem_we     = 1'b1;
                        state_next = S_OUT;
                    end
                    else if (stop_reg)
                        state_next = S_OUT;
                    else
                    begin
                        mem_addr   = pc_reg;
                        state_next = S_F0;
                    end
                end
            end
            S_F0:
            begin
                opc_next   = mem_rd[4:0];
                opbad_next = (mem_rd > WORD_W'(21));
                mem_addr   = pc_reg + ADDR_W'(1);
                state_next = S_F1;
            end
            S_F1:
            begin
                wa_next    = mem_rd;
                mem_addr   = pc_reg + ADDR_W'(2);
                state_next = S_F2;
            end
            S_F2:
            begin
                wb_next    = mem_rd;
                mem_addr   = pc_reg + ADDR_W'(3);
                // prefetch top of stack for pop and ret
                stk_addr   = lvl_reg[SP_W-1:0] - 1'b1;
                state_next = S_F3;
            end
            S_F3:
            begin
                wc_next    = mem_rd;
                stk_addr   = lvl_reg[SP_W-1:0] - 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_OUT;
                if (opbad_reg)
                begin
                    o_flt_next = FAULT_OPCODE;
                    stop_next  = 1'b1;
                end
                else
                begin
                    case (opc_reg)
                        OP_HALT: stop_next = 1'b1;
                        OP_SET, OP_POP, OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD,
                        OP_AND, OP_OR, OP_NOT, OP_RMEM, OP_IN:
                        begin
                            if (!dst_ok)
                            begin
                                o_flt_next = FAULT_DEST;
                                stop_next  = 1'b1;
                            end
                            else
                            begin
                                rwe = 1'b1;
                                case (opc_reg)
                                    OP_SET:
                                    begin
                                        rval = vb;
                                        pc_next = pc_reg + ADDR_W'(3);
                                    end
                                    OP_POP:
                                    begin
                                        if (empty)
                                        begin
                                            rwe = 1'b0;
                                            o_flt_next = FAULT_EMPTY;
                                            stop_next  = 1'b1;
                                        end
                                        else
                                        begin
                                            rval = stk_rd;
                                            lvl_next = lvl_reg - 1'b1;
                                            pc_next = pc_reg + ADDR_W'(2);
                                        end
                                    end
                                    OP_EQ:
                                    begin
                                        rval = WORD_W'(vb == vc);
                                        pc_next = pc_reg + ADDR_W'(4);
                                    end
                                    OP_GT:
                                    begin
                                        rval = WORD_W'(vb > vc);
                                        pc_next = pc_reg + ADDR_W'(4);
                                    end
                                    OP_ADD:
                                    begin
                                        rval = {1'b0, vb[14:0] + vc[14:0]};
                                        pc_next = pc_reg + ADDR_W'(4);
                                    end
                                    OP_MULT:
                                    begin
                                        rval = {1'b0, prod[14:0]};
                                        pc_next = pc_reg + ADDR_W'(4);
                                    end
                                    OP_MOD:
                                    begin
                                        rwe = 1'b0;
                                        if (vc == '0)
                                        begin
                                            o_flt_next = FAULT_MODZERO;
                                            stop_next  = 1'b1;
                                        end
                                        else
                                        begin
                                            dreq.start    = 1'b1;
                                            dreq.dividend = vb;
                                            dreq.divisor  = vc;
                                            state_next    = S_DIV;
                                        end
                                    end
                                    OP_AND:
                                    begin
                                        rval = vb & vc;
                                        pc_next = pc_reg + ADDR_W'(4);
                                    end
                                    OP_OR:
                                    begin
                                        rval = vb | vc;
                                        pc_next = pc_reg + ADDR_W'(4);
                                    end
                                    OP_NOT:
                                    begin
                                        rval = {1'b0, ~vb[14:0]};
                                        pc_next = pc_reg + ADDR_W'(3);
                                    end
                                    OP_RMEM:
                                    begin
                                        rwe = 1'b0;
                                        mem_addr = vb[14:0];
                                        state_next = S_DATA;
                                    end
                                    default:
                                    begin
                                        rval = {8'd0, inc_reg};
                                        o_it_next = 1'b1;
                                        pc_next = pc_reg + ADDR_W'(2);
                                    end
                                endcase
                            end
                        end
                        OP_PUSH:
                        begin
                            if (full)
                            begin
                                o_flt_next = FAULT_FULL;
                                stop_next  = 1'b1;
                            end
                            else
                            begin
                                stk_addr  = lvl_reg[SP_W-1:0];
                                stk_wdata = va;
                                stk_we    = 1'b1;
                                lvl_next  = lvl_reg + 1'b1;
                                pc_next   = pc_reg + ADDR_W'(2);
                            end
                        end
                        OP_JMP: pc_next = va[14:0];
                        OP_JT:  pc_next = (va != '0) ? vb[14:0] : pc_reg + ADDR_W'(3);
                        OP_JF:  pc_next = (va == '0) ? vb[14:0] : pc_reg + ADDR_W'(3);
                        OP_WMEM:
                        begin
                            mem_addr  = va[14:0];
                            mem_wdata = vb;
                            mem_we    = 1'b1;
                            pc_next   = pc_reg + ADDR_W'(3);
                        end
                        OP_CALL:
                        begin
                            if (full)
                            begin
                                o_flt_next = FAULT_FULL;
                                stop_next  = 1'b1;
                            end
                            else
                            begin
                                stk_addr  = lvl_reg[SP_W-1:0];
                                stk_wdata = {1'b0, pc_reg + ADDR_W'(2)};
                                stk_we    = 1'b1;
                                lvl_next  = lvl_reg + 1'b1;
                                pc_next   = va[14:0];
                            end
                        end
                        OP_RET:
                        begin
                            if (empty)
                            begin
                                o_flt_next = FAULT_EMPTY;
                                stop_next  = 1'b1;
                            end
                            else
                            begin
                                lvl_next = lvl_reg - 1'b1;
                                pc_next  = stk_rd[14:0];
                            end
                        end
                        OP_OUT:
                        begin
                            o_ov_next = 1'b1;
                            o_ch_next = va[7:0];
                            pc_next   = pc_reg + ADDR_W'(2);
                        end
                        default: pc_next = pc_reg + ADDR_W'(1);
                    endcase
                end
                o_pc_next = pc_next;
            end
            S_DATA:
            begin
                rwe        = 1'b1;
                rval       = mem_rd;
                pc_next    = pc_reg + ADDR_W'(3);
                o_pc_next  = pc_next;
                state_next = S_OUT;
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    rwe        = 1'b1;
                    rval       = drsp.remainder;
                    pc_next    = pc_reg + ADDR_W'(4);
                    o_pc_next  = pc_next;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (m_axis_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pc_reg    <= '0;
            lvl_reg   <= '0;
            stop_reg  <= 1'b0;
            clr_reg   <= '0;
            for (int i = 0; i < 8; i++)
                regs_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            lvl_reg   <= lvl_next;
            stop_reg  <= stop_next;
            clr_reg   <= clr_next;
            if (rwe)
                regs_reg[rsel] <= rval;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        opc_reg   <= opc_next;
        opbad_reg <= opbad_next;
        wa_reg    <= wa_next;
        wb_reg    <= wb_next;
        wc_reg    <= wc_next;
        inc_reg   <= inc_next;
        o_pc_reg  <= o_pc_next;
        o_ch_reg  <= o_ch_next;
        o_flt_reg <= o_flt_next;
        o_ov_reg  <= o_ov_next;
        o_it_reg  <= o_it_next;
    end

    // result port
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {6'd0, o_flt_reg, o_ch_reg, o_pc_reg};
    assign m_axis_tuser  = {stop_reg, o_it_reg, o_ov_reg};
endmodule

[tb/tb_sixteen_bit_stack_vm_core_unit.sv]
`timescale 1ns / 1ps
module tb_sixteen_bit_stack_vm_core_unit;
    import sbsvm_pkg::*;

    localparam int DEPTH      = 4096;
    localparam int NUM_ITEMS  = 1950;
    localparam int IDLE_LIMIT = 200000;

    typedef struct {
        logic [14:0] pc;
        logic        out_valid;
        logic [7:0]  out_char;
        logic        in_taken;
        logic        halted;
        fault_t      fault;
    } vm_result_t;

    // shadow copy of the machine and the queue of results it predicts
    class vm_shadow;
        logic [15:0]   mem [32768];
        logic [15:0]   regs [8];
        logic [15:0]   stk [DEPTH];
        int unsigned   sp;
        logic [14:0]   pc;
        bit            stopped;
        vm_result_t    pending[$];
        int            mismatches;
        int            results;
        int            steps;
        int            loads;
        int            outs;
        fault_t        last_fault;

        function new();
            foreach (mem[i]) mem[i] = '0;
            foreach (regs[i]) regs[i] = '0;
            foreach (stk[i]) stk[i] = '0;
            sp = 0;
            pc = '0;
            stopped = 0;
            last_fault = FAULT_NONE;
        endfunction

        function bit is_dest(logic [15:0] w);
            return (w >= 16'd32768) && (w <= 16'd32775);
        endfunction

        function logic [15:0] opval(logic [15:0] w);
            return is_dest(w) ? regs[w[2:0]] : w;
        endfunction

        function logic [15:0] word_at(int unsigned off);
            return mem[15'(pc + off)];
        endfunction

        function void note_request(bit op, logic [14:0] la, logic [15:0] lw, logic [7:0] ch);
            vm_result_t  r;
            logic [15:0] opc, wa, wb, wc, a, b, c;
            logic [31:0] res, nxt;
            bit          wr;
            fault_t      flt;
            r = '{default: '0, fault: FAULT_NONE};
            flt = FAULT_NONE;
            if (!op) begin
                mem[la] = lw;
                loads++;
            end
            else if (!stopped) begin
                steps++;
                opc = word_at(0);
                wa  = word_at(1);
                wb  = word_at(2);
                wc  = word_at(3);
                a   = opval(wa);
                b   = opval(wb);
                c   = opval(wc);
                nxt = 32'(pc);
                res = 0;
                wr  = 0;
                case (opc)
                    OP_HALT: stopped = 1;
                    OP_SET, OP_POP, OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND,
                    OP_OR, OP_NOT, OP_RMEM, OP_IN:
                    begin
                        if (!is_dest(wa)) flt = FAULT_DEST;
                        else begin
                            case (opc)
                                OP_SET: begin res = 32'(b); nxt += 3; end
                                OP_POP:
                                    if (sp == 0) flt = FAULT_EMPTY;
                                    else begin sp--; res = 32'(stk[sp]); nxt += 2; end
                                OP_EQ:   begin res = 32'(b == c); nxt += 4; end
                                OP_GT:   begin res = 32'(b > c); nxt += 4; end
                                OP_ADD:  begin res = (32'(b) + c) & 32'h7FFF; nxt += 4; end
                                OP_MULT: begin res = (32'(b) * c) & 32'h7FFF; nxt += 4; end
                                OP_MOD:
                                    if (c == 0) flt = FAULT_MODZERO;
                                    else begin res = 32'(b % c); nxt += 4; end
                                OP_AND:  begin res = 32'(b & c); nxt += 4; end
                                OP_OR:   begin res = 32'(b | c); nxt += 4; end
                                OP_NOT:  begin res = (~32'(b)) & 32'h7FFF; nxt += 3; end
                                OP_RMEM: begin res = 32'(mem[b[14:0]]); nxt += 3; end
                                default: begin res = 32'(ch); r.in_taken = 1; nxt += 2; end
                            endcase
                            wr = (flt == FAULT_NONE);
                        end
                    end
                    OP_PUSH:
                        if (sp >= DEPTH) flt = FAULT_FULL;
                        else begin stk[sp] = a; sp++; nxt += 2; end
                    OP_JMP: nxt = 32'(a);
                    OP_JT:  nxt = (a != 0) ? 32'(b) : nxt + 3;
                    OP_JF:  nxt = (a == 0) ? 32'(b) : nxt + 3;
                    OP_WMEM: begin mem[a[14:0]] = b; nxt += 3; end
                    OP_CALL:
                        if (sp >= DEPTH) flt = FAULT_FULL;
                        else begin
                            stk[sp] = 16'(15'(pc + 2));
                            sp++;
                            nxt = 32'(a);
                        end
                    OP_RET:
                        if (sp == 0) flt = FAULT_EMPTY;
                        else begin sp--; nxt = 32'(stk[sp]); end
                    OP_OUT: begin
                        r.out_valid = 1;
                        r.out_char  = a[7:0];
                        outs++;
                        nxt += 2;
                    end
                    OP_NOOP: nxt += 1;
                    default: flt = FAULT_OPCODE;
                endcase
                if (flt != FAULT_NONE) begin
                    stopped = 1;
                    r.in_taken = 0;
                    last_fault = flt;
                end
                else begin
                    if (wr) regs[wa[2:0]] = res[15:0];
                    pc = nxt[14:0];
                end
            end
            r.pc = pc;
            r.halted = stopped;
            r.fault = flt;
            pending.push_back(r);
        endfunction

        function void check_result(vm_result_t got);
            vm_result_t want;
            bit         bad;
            results++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pc=%0d fault=%0d", got.pc, got.fault);
                return;
            end
            want = pending.pop_front();
            bad = (got.pc !== want.pc) || (got.out_valid !== want.out_valid)
                || (got.out_char !== want.out_char) || (got.in_taken !== want.in_taken)
                || (got.halted !== want.halted) || (got.fault !== want.fault);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch #%0d: exp pc=%0d ov=%0b oc=%02h it=%0b h=%0b f=%0d",
                        mismatches, want.pc, want.out_valid, want.out_char, want.in_taken,
                        want.halted, want.fault);
                    $display("    got pc=%0d ov=%0b oc=%02h it=%0b h=%0b f=%0d",
                        got.pc, got.out_valid, got.out_char, got.in_taken, got.halted,
                        got.fault);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // load_address, load_word, in_char
    logic        s_axis_tuser;   // op
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // pc, out_char, fault
    logic [2:0]  m_axis_tuser;   // out_valid, in_taken, halted

    vm_shadow machine;
    bit       quiet;
    int       sent;
    int       idle_cycles;
    vm_result_t got;

    sixteen_bit_stack_vm_core_unit #(.STACK_DEPTH(DEPTH)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // sample both channels, predict, check and watch for a stall
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                machine.note_request(s_axis_tuser, s_axis_tdata[14:0],
                    s_axis_tdata[30:15], s_axis_tdata[38:31]);
            if (m_axis_tvalid && m_axis_tready) begin
                got.pc        = m_axis_tdata[14:0];
                got.out_char  = m_axis_tdata[22:15];
                got.fault     = fault_t'(m_axis_tdata[25:23]);
                got.out_valid = m_axis_tuser[0];
                got.in_taken  = m_axis_tuser[1];
                got.halted    = m_axis_tuser[2];
                machine.check_result(got);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout with %0d results outstanding", machine.pending.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // result side back-pressure in random bursts
    initial
    begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 9) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            m_axis_tready = 1'b1;
        end
    end

    // one request; entered and left at a falling edge
    task automatic send(bit op, logic [14:0] addr, logic [15:0] word, logic [7:0] ch);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = {1'b0, ch, word, addr};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        sent++;
        if (sent > NUM_ITEMS * 85 / 100) quiet = 1;
    endtask

    task automatic step_once();
        send(1'b1, 15'($urandom), 16'($urandom), 8'($urandom));
    endtask

    // place one instruction at the current pc and execute it
    task automatic run_instr(logic [15:0] w0, logic [15:0] w1, logic [15:0] w2,
                             logic [15:0] w3);
        logic [14:0] p;
        p = machine.pc;
        send(1'b0, p, w0, 8'($urandom));
        send(1'b0, 15'(p + 1), w1, 8'($urandom));
        send(1'b0, 15'(p + 2), w2, 8'($urandom));
        send(1'b0, 15'(p + 3), w3, 8'($urandom));
        step_once();
    endtask

    function automatic logic [15:0] any_operand();
        if ($urandom_range(0, 1)) return 16'(32768 + $urandom_range(0, 7));
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] any_reg();
        return 16'(32768 + $urandom_range(0, 7));
    endfunction

    // a random instruction that keeps the machine running
    task automatic run_random_instr();
        logic [15:0] opc, wa, wb, wc;
        opc = 16'($urandom_range(1, 21));
        if ((opc == OP_POP || opc == OP_RET) && machine.sp == 0) opc = OP_PUSH;
        if ((opc == OP_PUSH || opc == OP_CALL) && machine.sp >= DEPTH) opc = OP_POP;
        wa = any_operand();
        wb = any_operand();
        wc = any_operand();
        case (opc)
            OP_SET, OP_POP, OP_EQ, OP_GT, OP_ADD, OP_MULT, OP_MOD, OP_AND, OP_OR,
            OP_NOT, OP_RMEM, OP_IN: wa = any_reg();
            default: ;
        endcase
        // nonzero literal divisor
        if (opc == OP_MOD && machine.opval(wc) == 0) wc = 16'($urandom_range(1, 32767));
        run_instr(opc, wa, wb, wc);
    endtask

    // two-instruction loop at the pc, stepped until the machine stops
    task automatic run_loop(logic [15:0] opc);
        logic [14:0] p;
        p = machine.pc;
        send(1'b0, p, opc, 8'($urandom));
        send(1'b0, 15'(p + 1), any_reg(), 8'($urandom));
        send(1'b0, 15'(p + 2), OP_JMP, 8'($urandom));
        send(1'b0, 15'(p + 3), 16'(p), 8'($urandom));
        while (!machine.stopped) step_once();
    endtask

    initial
    begin
        int ending;
        machine = new();
        quiet = 0;
        sent = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser = 1'b0;
        s_axis_tdata = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed: extreme values, wrap-around arithmetic and control flow
        run_instr(OP_SET, 16'd32768, 16'd32767, 16'd0);
        run_instr(OP_ADD, 16'd32775, 16'd32768, 16'd1);
        run_instr(OP_MULT, 16'd32769, 16'd65535, 16'd32768);
        run_instr(OP_NOT, 16'd32770, 16'd0, 16'd0);
        run_instr(OP_OUT, 16'd255, 16'd0, 16'd0);
        send(1'b0, 15'h7FFF, 16'hFFFF, 8'hFF);
        run_instr(OP_IN, 16'd32771, 16'd0, 16'd0);
        run_instr(OP_RMEM, 16'd32772, 16'd65535, 16'd0);
        run_instr(OP_CALL, 16'd65535, 16'd0, 16'd0);
        run_instr(OP_RET, 16'd0, 16'd0, 16'd0);
        run_instr(OP_MOD, 16'd32773, 16'd65535, 16'd32768);

        // random instruction stream with fresh code at each pc
        while (sent < NUM_ITEMS) run_random_instr();

        // finish the machine by halt or by one of the faults
        ending = $urandom_range(0, 4);
        case (ending)
            0: run_instr(OP_HALT, 16'($urandom), 16'($urandom), 16'($urandom));
            1: run_instr(16'($urandom_range(22, 65535)), 16'($urandom), 16'($urandom),
                         16'($urandom));
            2: run_instr($urandom_range(0, 1) ? OP_POP : OP_SET,
                         16'($urandom_range(0, 32767)), 16'($urandom), 16'($urandom));
            3: run_loop(OP_POP);
            default: run_instr(OP_MOD, any_reg(), 16'($urandom), 16'd0);
        endcase
        // a stopped machine still accepts loads and ignores steps
        step_once();
        send(1'b0, 15'($urandom), 16'($urandom), 8'($urandom));
        step_once();
        s_axis_tvalid = 1'b0;

        while (machine.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        $display("run covered %0d steps, %0d loads, %0d characters out", machine.steps,
                 machine.loads, machine.outs);
        $display("machine stopped with fault code %0d, %0d results checked",
                 machine.last_fault, machine.results);
        if (machine.mismatches == 0 && machine.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[filelist.f]
hw/rtl/sbsvm_pkg.sv
hw/rtl/sbsvm_mod_unit.sv
hw/rtl/sixteen_bit_stack_vm_core_unit.sv
tb/tb_sixteen_bit_stack_vm_core_unit.sv
